// ===== design/poct_pkg.sv =====
// Shared types and codes for the patch operation coalescing table.
package poct_pkg;

   localparam int PATH_COUNT_DEF = 1024;
   localparam int TIME_BITS_DEF  = 24;

   localparam logic OPCODE_APPLY = 1'b0;
   localparam logic OPCODE_READ  = 1'b1;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_ADD     = 2'd1;
   localparam logic [1:0] KIND_REPLACE = 2'd2;
   localparam logic [1:0] KIND_REMOVE  = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  path_index;
      logic [1:0]  op_kind;
      logic [15:0] patch_number;
      logic [15:0] value_number;
   } req_type;

   typedef struct packed {
      logic        present;
      logic [1:0]  merged_kind;
      logic [9:0]  entry_path;
      logic [15:0] entry_patch;
      logic [15:0] entry_value;
      logic [23:0] created_at;
      logic [23:0] changed_at;
   } rsp_type;

   // Kind/value word of one table entry.
   typedef struct packed {
      logic        present;
      logic [1:0]  kind;
      logic [15:0] patch;
      logic [15:0] value;
   } kv_type;

endpackage

// ===== design/poct_ram.sv =====
// Single write port, single read port memory with registered read data.
module poct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/poct_fold.sv =====
// Folds one operation into a stored table entry.
module poct_fold #(
   parameter int TIME_BITS = 24
) (
   input  poct_pkg::req_type        req,
   input  logic                     apply,
   input  logic [TIME_BITS-1:0]     op_time,
   input  poct_pkg::kv_type         old_kv,
   input  logic [TIME_BITS-1:0]     old_created,
   input  logic [TIME_BITS-1:0]     old_changed,
   output poct_pkg::kv_type         new_kv,
   output logic [TIME_BITS-1:0]     new_created,
   output logic [TIME_BITS-1:0]     new_changed
);
   import poct_pkg::*;

   always_comb begin
      new_kv      = old_kv;
      new_created = old_created;
      new_changed = old_changed;
      if (apply) begin
         new_kv.present = 1'b1;
         new_kv.kind    = req.op_kind;
         new_kv.patch   = req.patch_number;
         new_kv.value   = req.value_number;
         new_changed    = op_time;
         if (!old_kv.present) begin
            new_created = op_time;
         end else if (old_kv.kind == KIND_REMOVE && req.op_kind == KIND_ADD) begin
            new_kv.kind = KIND_REPLACE;
         end else if (old_kv.kind == KIND_ADD && req.op_kind == KIND_REMOVE) begin
            new_kv.kind  = KIND_NONE;
            new_kv.patch = '0;
            new_kv.value = '0;
         end else if (old_kv.kind == KIND_ADD && req.op_kind == KIND_REPLACE) begin
            new_kv.kind = KIND_ADD;
         end else if (old_kv.kind == KIND_REPLACE && req.op_kind == KIND_REMOVE) begin
            new_created = op_time;
         end
      end
   end

endmodule

// ===== design/patch_op_coalescing_table_top.sv =====
// Patch operation coalescing table: one folded entry per path, with global op time.
//
// Requests arrive on req_* (valid/stall) and carry an opcode: apply folds an
// add, replace or remove into the entry of path_index, read returns it as is.
// Every accepted request yields exactly one response on rsp_*, the entry
// after any update, in request order.
// A request passes the s1 stage register and then the output register.
// Throughput: one request per cycle while req_stall is low; the entry memory is
// read in the accept cycle and written back as the request leaves the s1 stage,
// and a request to the path just written gets that entry from a forwarding register.
// Reset: synchronous. After reset the block runs a clearing pass over the
// entry memories, one entry per cycle over all PATH_COUNT entries, with req_stall
// held high; the operation time counter restarts from zero.
// A stalled response holds in the output register; the pipeline stage behind
// it holds too and req_stall rises until the response is taken.
// Paths at or above PATH_COUNT are not stored and return a blank entry.
module patch_op_coalescing_table_top #(
   parameter int PATH_COUNT = poct_pkg::PATH_COUNT_DEF,
   parameter int TIME_BITS  = poct_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  poct_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output poct_pkg::rsp_type rsp_payload
);
   import poct_pkg::*;

   localparam int AW = $clog2(PATH_COUNT);
   localparam int KW = $bits(kv_type);
   localparam int TW = 2 * TIME_BITS;

   // clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // pipeline stage behind the memory read
   logic          s1_valid_ff, s1_valid_in;
   req_type       s1_req_ff;
   logic          s1_range_ff;
   logic [AW-1:0] s1_addr_ff;

   // forwarding of the entry written in the accept cycle
   logic          fwd_ff, fwd_in;
   kv_type        fwd_kv_ff;
   logic [TW-1:0] fwd_tm_ff;

   logic [TIME_BITS-1:0] cnt_ff, cnt_in;
   logic                 started_ff, started_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic          accept, s1_adv, apply, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          req_range;
   logic [KW-1:0] kv_rd, kv_wr;
   logic [TW-1:0] tm_rd, tm_wr;
   kv_type        old_kv, new_kv;
   logic [TW-1:0] old_tm;
   logic [TIME_BITS-1:0] op_time, new_created, new_changed;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = AW'(req_payload.path_index);
   assign req_range = 32'(req_payload.path_index) < 32'(PATH_COUNT);

   assign apply = s1_range_ff && s1_req_ff.opcode == OPCODE_APPLY
                  && s1_req_ff.op_kind != KIND_NONE;

   assign wr_en   = clearing_ff || (s1_adv && apply);
   assign wr_addr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign kv_wr   = clearing_ff ? '0 : KW'(new_kv);
   assign tm_wr   = clearing_ff ? '0 : {new_created, new_changed};

   poct_ram #(.WIDTH(KW), .DEPTH(PATH_COUNT)) u_kv_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (kv_wr),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (kv_rd)
   );

   poct_ram #(.WIDTH(TW), .DEPTH(PATH_COUNT)) u_tm_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tm_wr),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (tm_rd)
   );

   assign old_kv = fwd_ff ? fwd_kv_ff : kv_type'(kv_rd);
   assign old_tm = fwd_ff ? fwd_tm_ff : tm_rd;

   // first applied op is time zero, then counts up and saturates
   always_comb begin
      if (!started_ff) begin
         op_time = '0;
      end else if (cnt_ff != '1) begin
         op_time = cnt_ff + 1'b1;
      end else begin
         op_time = cnt_ff;
      end
   end

   poct_fold #(.TIME_BITS(TIME_BITS)) u_fold (
      .req         (s1_req_ff),
      .apply       (apply),
      .op_time     (op_time),
      .old_kv      (old_kv),
      .old_created (old_tm[TW-1:TIME_BITS]),
      .old_changed (old_tm[TIME_BITS-1:0]),
      .new_kv      (new_kv),
      .new_created (new_created),
      .new_changed (new_changed)
   );

   always_comb begin
      clearing_in  = clearing_ff;
      clr_addr_in  = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(PATH_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      fwd_in = fwd_ff;
      if (accept) begin
         fwd_in = s1_adv && apply && s1_addr_ff == rd_addr;
      end

      cnt_in     = cnt_ff;
      started_in = started_ff;
      if (s1_adv && apply) begin
         cnt_in     = op_time;
         started_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      rsp_payload_in            = '0;
      rsp_payload_in.entry_path = s1_req_ff.path_index;
      if (s1_range_ff && new_kv.present) begin
         rsp_payload_in.present     = 1'b1;
         rsp_payload_in.merged_kind = new_kv.kind;
         rsp_payload_in.entry_patch = new_kv.patch;
         rsp_payload_in.entry_value = new_kv.value;
         rsp_payload_in.created_at  = 24'(new_created);
         rsp_payload_in.changed_at  = 24'(new_changed);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_payload;
         s1_range_ff <= req_range;
         s1_addr_ff  <= rd_addr;
         fwd_kv_ff   <= new_kv;
         fwd_tm_ff   <= {new_created, new_changed};
      end
      if (s1_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
